FILE: src/mrrc_pkg.sv
// package for the modbus rtu request checker
// holds default frame limits, verdict and function codes, and the crc-16/modbus byte update
// no dependencies
package mrrc_pkg;

    // default frame size limits in bytes, crc included
    localparam int MIN_FRAME_BYTES_DEF = 4;
    localparam int MAX_FRAME_BYTES_DEF = 256;

    // fixed field widths
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 9;
    localparam int CRC_W       = 16;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // exception reply length and its index width
    localparam int REPLY_LEN   = 5;
    localparam int REPLY_IDX_W = $clog2(REPLY_LEN);

    // crc-16/modbus
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    // function codes
    localparam logic [BYTE_W-1:0] FC_READ_COILS  = 8'h01;
    localparam logic [BYTE_W-1:0] FC_WRITE_COIL  = 8'h05;
    localparam logic [BYTE_W-1:0] FC_EXC_FLAG    = 8'h80;
    localparam logic [BYTE_W-1:0] EXC_ILLEGAL_FN = 8'h01;
    localparam logic [BYTE_W-1:0] ADDR_BROADCAST = 8'h00;

    // register indexes
    localparam logic REG_SLAVE_ADDRESS = 1'b0;

    typedef enum logic [1:0] {
        VERDICT_REPLY   = 2'd0,
        VERDICT_DROP    = 2'd1,
        VERDICT_HANDLER = 2'd2
    } t_verdict;

    // one byte of crc-16/modbus, lsb first
    function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: src/modbus_rtu_request_checker.sv
// modbus rtu request checker, top level
// depends on mrrc_pkg for limits, codes and the crc byte update

// Checks received Modbus RTU requests one byte per cycle while no final byte waits. Each
// request byte enters on the s_axis side (tlast on the final byte) and passes an input
// register; the next stage folds it into a running CRC-16/MODBUS, a saturating byte count and
// the address and function bytes. On the final byte the frame is judged: dropped (verdict 1)
// when shorter than MIN_FRAME_BYTES, longer than MAX_FRAME_BYTES, addressed to neither
// slave_address nor broadcast 0, or with a nonzero crc residue; handed to a handler
// (verdict 2) for function codes 1 and 5; otherwise answered with a five-byte
// illegal-function exception reply (verdict 0). Every result carries the function byte and
// the frame length, saturated at MAX_FRAME_BYTES. Rate: mid-frame bytes are taken in every
// cycle. A frame gives one result, or five for an exception reply, sent by the reply serializer;
// a final byte waits in the input register while the previous frame's results are still going
// out and moves on at the edge where the last of them is taken, so a waiting frame's results
// follow the previous frame's with no gap. That hand-over makes s_axis_tready follow
// m_axis_tready combinationally while a final byte waits. slave_address (reset 1) lies at apb
// byte address 0; write it only while no request is in flight. There is no clearing pass after reset.
module modbus_rtu_request_checker #(
    parameter int MIN_FRAME_BYTES = mrrc_pkg::MIN_FRAME_BYTES_DEF,
    parameter int MAX_FRAME_BYTES = mrrc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // request byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tlast,   // rx_last

    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] tx_byte, [15:8] frame_function,
                                        // [24:16] frame_length, [31:25] zero
    output logic        m_axis_tlast,   // tx_last
    output logic [1:0]  m_axis_tuser,   // [1:0] verdict

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // count saturates one past the limit to mark an overlong frame
    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_FRAME_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_FRAME_BYTES);
    localparam logic [mrrc_pkg::REPLY_IDX_W-1:0] IDX_LAST =
        mrrc_pkg::REPLY_IDX_W'(mrrc_pkg::REPLY_LEN - 1);
    localparam logic [mrrc_pkg::REPLY_IDX_W-1:0] IDX_CRC_LO =
        mrrc_pkg::REPLY_IDX_W'(mrrc_pkg::REPLY_LEN - 2);

    // configuration register
    logic [7:0]  r_slave_addr;

    // input register
    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // frame state
    logic [15:0]      r_crc,  n_crc;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic [7:0]       r_addr, n_addr;
    logic [7:0]       r_func, n_func;

    // frame record being sent
    logic                  r_rec_vld;
    mrrc_pkg::t_verdict    r_rec_verdict, n_verdict;
    logic [7:0]            r_rec_addr;
    logic [7:0]            r_rec_func;
    logic [8:0]            r_rec_len, n_len;
    logic [mrrc_pkg::REPLY_IDX_W-1:0] r_idx;
    logic [15:0]           r_rcrc;

    logic       cfg_wr;
    logic       in_acc;
    logic       adv;
    logic       out_acc;
    logic       rec_done;
    logic       frame_ok;
    logic [7:0] tx_byte;
    logic       tx_last;

    // ---------------------------------------------------------------- apb
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (paddr[2] == mrrc_pkg::REG_SLAVE_ADDRESS) begin
            prdata = {24'd0, r_slave_addr};
        end
    end

    // ---------------------------------------------------------------- input side
    // a final byte may not leave the input register while a record is still going out,
    // except at the edge where the record's last result is taken
    assign adv           = r_in_vld && (!r_in_last || !r_rec_vld || rec_done);
    assign s_axis_tready = !r_in_vld || adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // ---------------------------------------------------------------- frame update
    always_comb begin
        n_crc  = mrrc_pkg::crc_update(r_crc, r_in_byte);
        n_cnt  = (r_cnt < CNT_SAT) ? r_cnt + CNT_W'(1) : r_cnt;
        n_addr = (r_cnt == '0) ? r_in_byte : r_addr;
        n_func = (r_cnt == CNT_W'(1)) ? r_in_byte : r_func;
        n_len  = (n_cnt > CNT_MAX) ? 9'(CNT_MAX) : 9'(n_cnt);

        frame_ok = (n_cnt >= CNT_MIN) && (n_cnt <= CNT_MAX)
                && ((n_addr == mrrc_pkg::ADDR_BROADCAST) || (n_addr == r_slave_addr))
                && (n_crc == '0);

        priority if (!frame_ok) begin
            n_verdict = mrrc_pkg::VERDICT_DROP;
        end else if ((n_func == mrrc_pkg::FC_READ_COILS)
                  || (n_func == mrrc_pkg::FC_WRITE_COIL)) begin
            n_verdict = mrrc_pkg::VERDICT_HANDLER;
        end else begin
            n_verdict = mrrc_pkg::VERDICT_REPLY;
        end
    end

    // ---------------------------------------------------------------- result side
    always_comb begin
        unique case (r_idx)
            3'd0:       tx_byte = r_rec_addr;
            3'd1:       tx_byte = r_rec_func | mrrc_pkg::FC_EXC_FLAG;
            3'd2:       tx_byte = mrrc_pkg::EXC_ILLEGAL_FN;
            3'd3:       tx_byte = r_rcrc[7:0];
            default:    tx_byte = r_rcrc[15:8];
        endcase
        if (r_rec_verdict != mrrc_pkg::VERDICT_REPLY) begin
            tx_byte = '0;
        end
    end

    // dropped and handler frames give one result, an exception reply five
    assign tx_last  = (r_rec_verdict != mrrc_pkg::VERDICT_REPLY) || (r_idx == IDX_LAST);
    assign out_acc  = m_axis_tvalid && m_axis_tready;
    assign rec_done = out_acc && tx_last;

    assign m_axis_tvalid = r_rec_vld;
    assign m_axis_tlast  = tx_last;
    assign m_axis_tuser  = r_rec_verdict;
    assign m_axis_tdata  = {7'd0, r_rec_len, r_rec_func, tx_byte};

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr  <= 8'd1;
            r_in_vld      <= 1'b0;
            r_crc         <= mrrc_pkg::CRC_INIT;
            r_cnt         <= '0;
            r_addr        <= '0;
            r_func        <= '0;
            r_rec_vld     <= 1'b0;
            r_rec_verdict <= mrrc_pkg::VERDICT_DROP;
            r_idx         <= '0;
        end else begin
            if (cfg_wr && (paddr[2] == mrrc_pkg::REG_SLAVE_ADDRESS)) begin
                r_slave_addr <= pwdata[7:0];
            end

            // input register
            if (in_acc) begin
                r_in_vld  <= 1'b1;
                r_in_byte <= s_axis_tdata;
                r_in_last <= s_axis_tlast;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end

            // frame state, cleared after the final byte
            if (adv) begin
                if (r_in_last) begin
                    r_crc  <= mrrc_pkg::CRC_INIT;
                    r_cnt  <= '0;
                    r_addr <= '0;
                    r_func <= '0;
                end else begin
                    r_crc  <= n_crc;
                    r_cnt  <= n_cnt;
                    r_addr <= n_addr;
                    r_func <= n_func;
                end
            end

            // record load and reply serializer
            if (adv && r_in_last) begin
                r_rec_vld     <= 1'b1;
                r_rec_verdict <= n_verdict;
                r_rec_addr    <= n_addr;
                r_rec_func    <= n_func;
                r_rec_len     <= n_len;
                r_idx         <= '0;
                r_rcrc        <= mrrc_pkg::CRC_INIT;
            end else if (rec_done) begin
                r_rec_vld <= 1'b0;
                r_idx     <= '0;
            end else if (out_acc) begin
                r_idx <= r_idx + mrrc_pkg::REPLY_IDX_W'(1);
                // reply crc covers the three leading bytes
                if (r_idx < IDX_CRC_LO) begin
                    r_rcrc <= mrrc_pkg::crc_update(r_rcrc, tx_byte);
                end
            end
        end
    end

    // ---------------------------------------------------------------- checks
`ifndef NO_ASSERTIONS
    // a final byte held back by a busy record stays in the input register
    a_last_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_in_last && r_rec_vld && !rec_done) |=> r_in_vld)
        else $error("final byte lost while record busy");

    // frame state is back at its reset value after a final byte
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_last) |=> (r_cnt == '0 && r_crc == mrrc_pkg::CRC_INIT))
        else $error("frame state not cleared after final byte");

    // the serializer never runs past the reply
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rec_vld |-> (r_idx <= IDX_LAST))
        else $error("reply index out of range");

    // only exception replies step the serializer
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rec_vld && r_rec_verdict != mrrc_pkg::VERDICT_REPLY) |-> (r_idx == '0))
        else $error("single-result frame stepped the serializer");
`endif

endmodule

FILE: sim/modbus_rtu_request_checker_tb.sv
// self-checking testbench for the modbus rtu request checker
// streams request bytes, predicts every result and compares it field by field
// depends on mrrc_pkg and the modbus_rtu_request_checker rtl
`timescale 1ns / 1ps

module modbus_rtu_request_checker_tb;

    localparam int MIN_BYTES = mrrc_pkg::MIN_FRAME_BYTES_DEF;
    localparam int MAX_BYTES = mrrc_pkg::MAX_FRAME_BYTES_DEF;
    // byte address of the slave address register
    localparam logic [mrrc_pkg::APB_ADDR_W-1:0] SLAVE_ADDR_OFFSET =
        {mrrc_pkg::REG_SLAVE_ADDRESS, 2'b00};
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 20;

    typedef struct {
        logic [7:0] rx_byte;
        logic       rx_last;
    } t_req_byte;

    typedef struct {
        logic [7:0]         tx_byte;
        logic               tx_last;
        mrrc_pkg::t_verdict verdict;
        logic [7:0]         func;
        logic [8:0]         len;
    } t_result;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    // stimulus and checking state
    t_req_byte   pending_requests[$];
    t_result     expected_results[$];
    int          send_idle_pct   = 0;
    int          recv_stall_pct  = 0;
    bit          long_hold_arm   = 1'b0;
    bit          long_hold_taken = 1'b0;
    int          hold_left       = 0;
    int          mismatch_count  = 0;
    int          config_errors   = 0;

    // predicted block state
    logic [7:0]  cfg_slave_addr = 8'd1;
    logic [15:0] frame_crc      = mrrc_pkg::CRC_INIT;
    int          frame_count    = 0;
    logic [7:0]  frame_addr     = 8'h00;
    logic [7:0]  frame_func     = 8'h00;

    modbus_rtu_request_checker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [7:0] rx_byte
        .s_axis_tlast  (s_axis_tlast),    // rx_last
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [7:0] tx_byte, [15:8] function, [24:16] length
        .m_axis_tlast  (m_axis_tlast),    // tx_last
        .m_axis_tuser  (m_axis_tuser),    // [1:0] verdict
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // crc-16/modbus, one data bit at a time against the reflected polynomial
    function automatic logic [15:0] crc16_modbus_fold(input logic [15:0] crc,
                                                      input logic [7:0] data);
        logic feedback;
        for (int k = 0; k < 8; k++) begin
            feedback = crc[0] ^ data[k];
            crc = {1'b0, crc[15:1]} ^ (feedback ? mrrc_pkg::CRC_POLY : 16'h0000);
        end
        return crc;
    endfunction

    function automatic void expect_result(input logic [7:0] tx_byte, input logic tx_last,
                                          input mrrc_pkg::t_verdict verdict,
                                          input logic [8:0] len);
        t_result r;
        r.tx_byte = tx_byte;
        r.tx_last = tx_last;
        r.verdict = verdict;
        r.func    = frame_func;
        r.len     = len;
        expected_results.push_back(r);
    endfunction

    // folds one accepted request byte into the frame state, judges the frame on its last byte
    function automatic void absorb_request_byte(input logic [7:0] data, input logic last);
        logic [8:0]  len;
        logic [15:0] reply_crc;
        logic [7:0]  reply [3];
        bit          addr_ok;
        bit          frame_ok;
        if (frame_count == 0) begin
            frame_addr = data;
        end else if (frame_count == 1) begin
            frame_func = data;
        end
        frame_crc = crc16_modbus_fold(frame_crc, data);
        // saturate one past the limit so an overlong frame stays marked
        if (frame_count <= MAX_BYTES) begin
            frame_count++;
        end
        if (!last) begin
            return;
        end

        len      = 9'((frame_count > MAX_BYTES) ? MAX_BYTES : frame_count);
        addr_ok  = (frame_addr == mrrc_pkg::ADDR_BROADCAST) || (frame_addr == cfg_slave_addr);
        frame_ok = (frame_count >= MIN_BYTES) && (frame_count <= MAX_BYTES) && addr_ok &&
                   (frame_crc == 16'h0000);

        if (!frame_ok) begin
            expect_result(8'h00, 1'b1, mrrc_pkg::VERDICT_DROP, len);
        end else if (frame_func == mrrc_pkg::FC_READ_COILS ||
                     frame_func == mrrc_pkg::FC_WRITE_COIL) begin
            expect_result(8'h00, 1'b1, mrrc_pkg::VERDICT_HANDLER, len);
        end else begin
            // illegal function reply, broadcast included
            reply[0]  = frame_addr;
            reply[1]  = frame_func | mrrc_pkg::FC_EXC_FLAG;
            reply[2]  = mrrc_pkg::EXC_ILLEGAL_FN;
            reply_crc = mrrc_pkg::CRC_INIT;
            for (int i = 0; i < 3; i++) begin
                reply_crc = crc16_modbus_fold(reply_crc, reply[i]);
                expect_result(reply[i], 1'b0, mrrc_pkg::VERDICT_REPLY, len);
            end
            expect_result(reply_crc[7:0], 1'b0, mrrc_pkg::VERDICT_REPLY, len);
            expect_result(reply_crc[15:8], 1'b1, mrrc_pkg::VERDICT_REPLY, len);
        end

        frame_crc   = mrrc_pkg::CRC_INIT;
        frame_count = 0;
        frame_addr  = 8'h00;
        frame_func  = 8'h00;
    endfunction

    function automatic void compare_field(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            mismatch_count++;
        end
    endfunction

    // request driver: next byte from the pending queue once the current one is taken
    always @(posedge i_clk) begin : drive_requests
        t_req_byte nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_requests.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= nxt.rx_byte;
                s_axis_tlast  <= nxt.rx_last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls, plus one long hold-off counted here
    always @(posedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (long_hold_arm && !long_hold_taken) begin
            long_hold_taken <= 1'b1;
            hold_left       <= LONG_HOLD_CYCLES;
            m_axis_tready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: check results first, then predict from the request taken at this edge
    always @(posedge i_clk) begin : watch_streams
        t_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got tdata %h tlast %b tuser %h",
                             $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("tx_byte", 32'(want.tx_byte), 32'(m_axis_tdata[7:0]));
                    compare_field("frame_function", 32'(want.func), 32'(m_axis_tdata[15:8]));
                    compare_field("frame_length", 32'(want.len), 32'(m_axis_tdata[24:16]));
                    compare_field("tdata padding", 32'd0, 32'(m_axis_tdata[31:25]));
                    compare_field("tx_last", 32'(want.tx_last), 32'(m_axis_tlast));
                    compare_field("verdict", 32'(want.verdict), 32'(m_axis_tuser));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                absorb_request_byte(s_axis_tdata, s_axis_tlast);
            end
        end
    end

    task automatic queue_byte(input logic [7:0] data, input logic last);
        t_req_byte rb;
        rb.rx_byte = data;
        rb.rx_last = last;
        pending_requests.push_back(rb);
    endtask

    // well-formed request with random body; corrupt flips one crc bit
    task automatic queue_frame(input logic [7:0] addr, input logic [7:0] func,
                               input int body_len, input bit corrupt);
        logic [15:0] crc;
        logic [7:0]  data;
        crc = mrrc_pkg::CRC_INIT;
        queue_byte(addr, 1'b0);
        crc = crc16_modbus_fold(crc, addr);
        queue_byte(func, 1'b0);
        crc = crc16_modbus_fold(crc, func);
        for (int i = 0; i < body_len; i++) begin
            data = 8'($urandom_range(255));
            queue_byte(data, 1'b0);
            crc = crc16_modbus_fold(crc, data);
        end
        if (corrupt) begin
            crc = crc ^ (16'h0001 << $urandom_range(15));
        end
        queue_byte(crc[7:0], 1'b0);
        queue_byte(crc[15:8], 1'b1);
    endtask

    task automatic queue_noise(input int len);
        for (int i = 0; i < len; i++) begin
            queue_byte(8'($urandom_range(255)), i == len - 1);
        end
    endtask

    // mostly valid traffic for the current address, the rest broken or foreign
    task automatic queue_random_frame();
        int         pick;
        logic [7:0] addr;
        logic [7:0] func;
        pick = $urandom_range(99);
        if ($urandom_range(9) < 4) begin
            func = mrrc_pkg::FC_READ_COILS;
        end else if ($urandom_range(9) < 3) begin
            func = mrrc_pkg::FC_WRITE_COIL;
        end else begin
            func = 8'($urandom_range(255));
        end
        if (pick < 70) begin
            addr = ($urandom_range(4) == 0) ? mrrc_pkg::ADDR_BROADCAST : cfg_slave_addr;
            queue_frame(addr, func, $urandom_range(6), pick >= 60);
        end else if (pick < 80) begin
            do begin
                addr = 8'($urandom_range(255));
            end while (addr == cfg_slave_addr || addr == mrrc_pkg::ADDR_BROADCAST);
            queue_frame(addr, func, $urandom_range(6), 1'b0);
        end else if (pick < 90) begin
            queue_noise($urandom_range(1, 3));
        end else begin
            queue_noise($urandom_range(4, 12));
        end
    endtask

    // all requests taken and every result seen, then let the pipeline settle
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // apb write then read back
    task automatic write_slave_address(input logic [7:0] value);
        logic [31:0] readback;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SLAVE_ADDR_OFFSET;
        pwdata  <= {24'h000000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        cfg_slave_addr = value;
        if (readback !== {24'h000000, value}) begin
            $display("%0t: slave_address readback mismatch, expected %h, got %h",
                     $time, {24'h000000, value}, readback);
            config_errors++;
        end
    endtask

    task automatic run_phase(input logic [7:0] addr, input int send_pct, input int recv_pct,
                             input int byte_budget, input bit big_frames);
        write_slave_address(addr);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        while (pending_requests.size() < byte_budget) begin
            queue_random_frame();
            if (big_frames && pending_requests.size() > byte_budget / 2) begin
                // overlong frame, two bytes past the limit so the count stays saturated
                queue_frame(addr, mrrc_pkg::FC_READ_COILS, MAX_BYTES - 2, 1'b0);
                big_frames = 1'b0;
            end
        end
        wait_idle();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed frames at the reset address, no idling
        queue_noise(1);                                  // one byte, no function byte
        queue_noise(3);                                  // too short
        queue_frame(8'd1, mrrc_pkg::FC_READ_COILS, 0, 1'b0);     // shortest legal frame
        queue_frame(mrrc_pkg::ADDR_BROADCAST, mrrc_pkg::FC_WRITE_COIL, 2, 1'b0);
        queue_frame(8'd1, 8'h03, 1, 1'b0);               // exception reply
        queue_frame(mrrc_pkg::ADDR_BROADCAST, 8'hFF, 0, 1'b0);   // broadcast, unsupported
        queue_frame(8'd1, 8'h00, 0, 1'b0);
        queue_frame(8'd1, mrrc_pkg::FC_READ_COILS, 0, 1'b1);     // bad crc
        queue_frame(8'd2, mrrc_pkg::FC_READ_COILS, 0, 1'b0);     // foreign address
        wait_idle();

        // random phases across address settings and idling patterns
        run_phase(8'd0, 79, 0, 40, 1'b0);
        run_phase(8'd255, 0, 79, 40, 1'b0);
        run_phase(8'($urandom_range(1, 254)), 17, 17, 40, 1'b1);

        // receiver holds off long while the sender keeps going
        long_hold_arm = 1'b1;
        run_phase(8'd247, 0, 0, 40, 1'b0);

        if (expected_results.size() != 0) begin
            $display("%0t: %0d results never arrived, next expected tx_byte %h verdict %0d",
                     $time, expected_results.size(), expected_results[0].tx_byte,
                     expected_results[0].verdict);
        end
        if (mismatch_count == 0 && config_errors == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
